/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the dispatcher RTL.
// No dependencies; defining NO_ASSERTIONS compiles them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PTD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
`define PTD_ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error("forbidden condition");
`else
`define PTD_ASSERT(lbl, clk, rst_n, prop)
`define PTD_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

/* hw/rtl/ptd_pkg.sv */
// Package for the periodic task dispatcher: sizes, command and status codes,
// payload structs and the controller/datapath interface structs. No dependencies.
package ptd_pkg;

	localparam int NUM_SLOTS   = 8;
	localparam int PERIOD_BITS = 16;
	localparam int TICK_W      = 32;
	localparam int CNT_W       = 4;
	localparam int FUNC_W      = 2;
	localparam int SLOT_W      = 3;
	localparam int PER_W       = 16;
	localparam int STATUS_W    = 2;
	localparam int STEP_W      = $clog2(TICK_W + 1);

	localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_TASK = 2'd3;

	localparam logic [SLOT_W:0]  SLOT_LIMIT = (SLOT_W + 1)'(NUM_SLOTS);
	localparam logic [CNT_W-1:0] CNT_LIMIT  = CNT_W'(NUM_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SLOT_W-1:0] slot;
		logic [PER_W-1:0]  period;
	} ptd_cmd_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                due_valid;
		logic [SLOT_W-1:0]   due_slot;
		logic                last;
	} ptd_res_item_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic exec_cmd;
		logic tick_inc;
		logic scan_next;
		logic div_start;
		logic pend_update;
		logic final_push;
	} ptd_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic item_is_tick;
		logic tick_zero;
		logic slot_occ;
		logic scan_last;
		logic div_busy;
		logic rem_zero;
		logic pend_valid;
		logic out_free;
	} ptd_sts_t;

endpackage

/* hw/rtl/ptd_rem.sv */
// Bit-serial remainder unit: tick count modulo task period, restoring form,
// one dividend bit per cycle. Depends on ptd_pkg.
module ptd_rem (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ptd_pkg::TICK_W-1:0]      dividend,
	input  logic [ptd_pkg::PERIOD_BITS-1:0] divisor,
	output logic                           busy,
	output logic [ptd_pkg::PERIOD_BITS-1:0] rem
);
	import ptd_pkg::*;

	logic [STEP_W-1:0]      steps_q;
	logic [TICK_W-1:0]      dvd_q;
	logic [PERIOD_BITS-1:0] dsr_q;
	logic [PERIOD_BITS-1:0] rem_q;
	logic [PERIOD_BITS:0]   trial;
	logic [PERIOD_BITS:0]   diff;
	logic [PERIOD_BITS-1:0] rem_nxt;

	always_comb begin
		trial = {rem_q, dvd_q[TICK_W-1]};
		diff  = trial - {1'b0, dsr_q};
		if (trial >= {1'b0, dsr_q}) begin
			rem_nxt = diff[PERIOD_BITS-1:0];
		end else begin
			rem_nxt = trial[PERIOD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (start) begin
			steps_q <= STEP_W'(TICK_W);
		end else if (steps_q != '0) begin
			steps_q <= steps_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (steps_q != '0) begin
			dvd_q <= {dvd_q[TICK_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign busy = (steps_q != '0);
	assign rem  = rem_q;

endmodule

/* hw/rtl/ptd_dpath.sv */
// Dispatcher datapath: period table, task count, tick counter, slot scan,
// remainder unit and result register. Depends on ptd_pkg, ptd_rem, assert_macros.svh.
`include "assert_macros.svh"
module ptd_dpath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ptd_pkg::ptd_cmd_item_t cmd,
	input  ptd_pkg::ptd_ctl_t      ctl,
	output ptd_pkg::ptd_sts_t      sts,
	input  logic                   res_ready,
	output logic                   res_valid,
	output ptd_pkg::ptd_res_item_t res
);
	import ptd_pkg::*;

	ptd_cmd_item_t          item_q;
	logic [PERIOD_BITS-1:0] period_tbl_q [NUM_SLOTS];
	logic [CNT_W-1:0]       count_q;
	logic [TICK_W-1:0]      tick_q;
	logic [SLOT_W-1:0]      scan_idx_q;
	logic                   pend_valid_q;
	logic [SLOT_W-1:0]      pend_slot_q;
	logic                   out_valid_q;
	ptd_res_item_t          out_q;

	logic [SLOT_W-1:0]      rd_idx;
	logic [PERIOD_BITS-1:0] rd_period;
	logic                   slot_in_range;
	logic                   create_ok;
	logic                   delete_ok;
	logic [STATUS_W-1:0]    cmd_status;
	logic                   div_busy;
	logic [PERIOD_BITS-1:0] rem;
	logic                   out_free;
	logic                   push;
	ptd_res_item_t          push_res;

	assign rd_idx        = (item_q.func == FUNC_TICK) ? scan_idx_q : item_q.slot;
	assign rd_period     = period_tbl_q[rd_idx];
	assign slot_in_range = ({1'b0, item_q.slot} < SLOT_LIMIT);
	assign create_ok     = (item_q.period != '0) && (item_q.slot != '0) && slot_in_range
		&& (count_q < CNT_LIMIT);
	assign delete_ok     = slot_in_range && (count_q != '0) && (rd_period != '0);
	assign out_free      = !out_valid_q || res_ready;

	always_comb begin
		case (item_q.func)
			FUNC_CREATE: begin
				if ((item_q.period == '0) || (item_q.slot == '0) || !slot_in_range) begin
					cmd_status = ST_INVALID;
				end else if (count_q >= CNT_LIMIT) begin
					cmd_status = ST_FULL;
				end else begin
					cmd_status = ST_OK;
				end
			end
			FUNC_DELETE: cmd_status = delete_ok ? ST_OK : ST_NO_TASK;
			default:     cmd_status = ST_INVALID;
		endcase
	end

	always_comb begin
		push     = 1'b0;
		push_res = '{status: ST_OK, due_valid: 1'b0, due_slot: '0, last: 1'b1};
		if (ctl.exec_cmd) begin
			push            = 1'b1;
			push_res.status = cmd_status;
		end else if (ctl.pend_update && (rem == '0) && pend_valid_q) begin
			push               = 1'b1;
			push_res.due_valid = 1'b1;
			push_res.due_slot  = pend_slot_q;
			push_res.last      = 1'b0;
		end else if (ctl.final_push) begin
			push = 1'b1;
			if (pend_valid_q) begin
				push_res.due_valid = 1'b1;
				push_res.due_slot  = pend_slot_q;
			end
		end
	end

	ptd_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (tick_q),
		.divisor  (rd_period),
		.busy     (div_busy),
		.rem      (rem)
	);

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			item_q <= cmd;
		end
		if (push) begin
			out_q <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				period_tbl_q[i] <= '0;
			end
			count_q      <= '0;
			tick_q       <= '0;
			scan_idx_q   <= SLOT_W'(1);
			pend_valid_q <= 1'b0;
			pend_slot_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctl.exec_cmd) begin
				if (item_q.func == FUNC_CREATE && create_ok) begin
					period_tbl_q[item_q.slot] <= item_q.period[PERIOD_BITS-1:0];
					count_q <= count_q + 1'b1;
				end else if (item_q.func == FUNC_DELETE && delete_ok) begin
					period_tbl_q[item_q.slot] <= '0;
					count_q <= count_q - 1'b1;
				end
			end
			if (ctl.tick_inc) begin
				tick_q       <= tick_q + 1'b1;
				scan_idx_q   <= SLOT_W'(1);
				pend_valid_q <= 1'b0;
			end else if (ctl.scan_next) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (ctl.pend_update && (rem == '0)) begin
				pend_valid_q <= 1'b1;
				pend_slot_q  <= scan_idx_q;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.item_is_tick = (item_q.func == FUNC_TICK);
	assign sts.tick_zero    = (tick_q == '0);
	assign sts.slot_occ     = (rd_period != '0);
	assign sts.scan_last    = (scan_idx_q == SLOT_LAST);
	assign sts.div_busy     = div_busy;
	assign sts.rem_zero     = (rem == '0);
	assign sts.pend_valid   = pend_valid_q;
	assign sts.out_free     = out_free;

	assign res_valid = out_valid_q;
	assign res       = out_q;

	`PTD_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_LIMIT)
	`PTD_ASSERT(a_slot0_empty, clk, arst_n, period_tbl_q[0] == '0)
	`PTD_ASSERT(a_push_free, clk, arst_n, push |-> out_free)
	`PTD_ASSERT_NEVER(a_scan_idx_zero, clk, arst_n, scan_idx_q == '0)

endmodule

/* hw/rtl/ptd_ctrl.sv */
// Dispatcher controller: sequences command execution and the per-slot tick scan.
// Depends on ptd_pkg.
module ptd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  ptd_pkg::ptd_sts_t sts,
	output ptd_pkg::ptd_ctl_t ctl
);
	import ptd_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_CMD    = 4'd2;
	localparam logic [3:0] S_TINC   = 4'd3;
	localparam logic [3:0] S_SCAN   = 4'd4;
	localparam logic [3:0] S_DIV    = 4'd5;
	localparam logic [3:0] S_CHECK  = 4'd6;
	localparam logic [3:0] S_NEXT   = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load_item = 1'b1;
					state_nxt     = S_DECODE;
				end
			end
			S_DECODE: state_nxt = sts.item_is_tick ? S_TINC : S_CMD;
			S_CMD: begin
				if (sts.out_free) begin
					ctl.exec_cmd = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_TINC: begin
				ctl.tick_inc = 1'b1;
				state_nxt    = S_SCAN;
			end
			S_SCAN: begin
				if (sts.tick_zero || !sts.slot_occ) begin
					state_nxt = S_NEXT;
				end else begin
					ctl.div_start = 1'b1;
					state_nxt     = S_DIV;
				end
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!(sts.rem_zero && sts.pend_valid && !sts.out_free)) begin
					ctl.pend_update = 1'b1;
					state_nxt       = S_NEXT;
				end
			end
			S_NEXT: begin
				if (sts.scan_last) begin
					state_nxt = S_FIN;
				end else begin
					ctl.scan_next = 1'b1;
					state_nxt     = S_SCAN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					ctl.final_push = 1'b1;
					state_nxt      = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign cmd_ready = (state_q == S_IDLE);

endmodule

/* hw/rtl/periodic_task_dispatcher_unit.sv */
// Periodic task dispatcher top level. Depends on ptd_pkg, ptd_ctrl, ptd_dpath.
// Create, delete, unknown commands: decode, then execute once the output register is free.
// Tick: increment, scan slots 1 to 7; if the tick count is nonzero, occupied ones run the
// 32-step serial remainder unit; one item at a time, next one taken on return to idle.
// A result waits in the output register while the next transaction is accepted.
// Asynchronous active-low reset empties every slot and clears the task and tick counters.
module periodic_task_dispatcher_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  ptd_pkg::ptd_cmd_item_t cmd,
	output logic                   res_valid,
	input  logic                   res_ready,
	output ptd_pkg::ptd_res_item_t res
);
	import ptd_pkg::*;

	ptd_ctl_t ctl;
	ptd_sts_t sts;

	ptd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	ptd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule
